// ----- rtl/dq_pkg.sv -----
// Shared constants and codes for the double-ended queue.
`timescale 1ns / 1ps
`default_nettype none

package dq_pkg;

    localparam int DQ_DEPTH      = 64;
    localparam int DQ_DATA_WIDTH = 32;

    localparam int OP_W = 3;
    localparam int ST_W = 2;

    localparam logic [OP_W-1:0] OP_QUERY      = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd3;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd4;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

endpackage

`default_nettype wire

// ----- rtl/dq_ram.sv -----
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none

module dq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/double_ended_queue.sv -----
// Double-ended queue over a circular RAM, with front and back words cached.
// Queries, pushes, and pops that leave at most one word: result registered
// in the cycle after accept; one word per cycle while the output is free.
// Pops that leave two or more words pass through S_READ, where the registered
// RAM read fetches the new end word. The output register frees the input.
// Reset (synchronous, active low) empties the queue; the RAM is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module double_ended_queue #(
    parameter int DEPTH      = dq_pkg::DQ_DEPTH,
    parameter int DATA_WIDTH = dq_pkg::DQ_DATA_WIDTH,
    parameter int IDX_W      = $clog2(DEPTH),
    parameter int CNT_W      = $clog2(DEPTH + 1)
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_in_valid,
    output logic                         o_in_stall,
    input  wire logic [dq_pkg::OP_W-1:0] i_operation,
    input  wire logic [DATA_WIDTH-1:0]   i_value,
    output logic                         o_out_valid,
    input  wire logic                    i_out_stall,
    output logic [DATA_WIDTH-1:0]        o_popped_value,
    output logic [dq_pkg::ST_W-1:0]      o_status,
    output logic [CNT_W-1:0]             o_count,
    output logic [DATA_WIDTH-1:0]        o_front_value,
    output logic [DATA_WIDTH-1:0]        o_back_value
);

    import dq_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_READ
    } t_state;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

    t_state r_state, n_state;

    logic [IDX_W-1:0]      r_front_idx, n_front_idx;
    logic [IDX_W-1:0]      r_back_idx, n_back_idx;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [DATA_WIDTH-1:0] r_front_word, n_front_word;
    logic [DATA_WIDTH-1:0] r_back_word, n_back_word;
    logic [DATA_WIDTH-1:0] r_pend_popped, n_popped;
    logic                  r_pend_front, n_pend_front;
    logic [ST_W-1:0]       n_status;
    logic                  load_out;

    logic                  out_free;
    logic                  in_accept;

    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    logic                  rd_en;
    logic [IDX_W-1:0]      rd_addr;
    logic [DATA_WIDTH-1:0] rd_data;

    logic [IDX_W-1:0]      front_next, front_prev, back_next, back_prev, back_prev2;
    logic                  is_empty, is_full;

    assign out_free   = !o_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE) || !out_free;
    assign in_accept  = i_in_valid && !o_in_stall;

    assign front_next = (r_front_idx == LAST_IDX) ? '0 : r_front_idx + 1'b1;
    assign front_prev = (r_front_idx == '0) ? LAST_IDX : r_front_idx - 1'b1;
    assign back_next  = (r_back_idx == LAST_IDX) ? '0 : r_back_idx + 1'b1;
    assign back_prev  = (r_back_idx == '0) ? LAST_IDX : r_back_idx - 1'b1;
    assign back_prev2 = (back_prev == '0) ? LAST_IDX : back_prev - 1'b1;

    assign is_empty = (r_count == '0);
    assign is_full  = (r_count == CNT_W'(DEPTH));

    always_comb begin
        n_state      = r_state;
        n_front_idx  = r_front_idx;
        n_back_idx   = r_back_idx;
        n_count      = r_count;
        n_front_word = r_front_word;
        n_back_word  = r_back_word;
        n_popped     = '0;
        n_pend_front = r_pend_front;
        n_status     = ST_OK;
        load_out     = 1'b0;
        wr_en        = 1'b0;
        wr_addr      = r_back_idx;
        rd_en        = 1'b0;
        rd_addr      = front_next;

        if (r_state == S_READ) begin
            // new end word arrives from the RAM
            load_out = 1'b1;
            n_popped = r_pend_popped;
            n_state  = S_IDLE;
            if (r_pend_front) begin
                n_front_word = rd_data;
            end else begin
                n_back_word = rd_data;
            end
        end else if (in_accept) begin
            load_out = 1'b1;
            unique case (i_operation)
                OP_PUSH_BACK: begin
                    if (is_full) begin
                        n_status = ST_FULL;
                    end else begin
                        wr_en       = 1'b1;
                        wr_addr     = r_back_idx;
                        n_back_idx  = back_next;
                        n_count     = r_count + 1'b1;
                        n_back_word = i_value;
                        if (is_empty) begin
                            n_front_word = i_value;
                        end
                    end
                end
                OP_PUSH_FRONT: begin
                    if (is_full) begin
                        n_status = ST_FULL;
                    end else begin
                        wr_en        = 1'b1;
                        wr_addr      = front_prev;
                        n_front_idx  = front_prev;
                        n_count      = r_count + 1'b1;
                        n_front_word = i_value;
                        if (is_empty) begin
                            n_back_word = i_value;
                        end
                    end
                end
                OP_POP_FRONT: begin
                    if (is_empty) begin
                        n_status = ST_EMPTY;
                    end else begin
                        n_popped    = r_front_word;
                        n_front_idx = front_next;
                        n_count     = r_count - 1'b1;
                        if (r_count > CNT_W'(2)) begin
                            rd_en        = 1'b1;
                            rd_addr      = front_next;
                            n_pend_front = 1'b1;
                            n_state      = S_READ;
                            load_out     = 1'b0;
                        end else begin
                            n_front_word = r_back_word;
                        end
                    end
                end
                OP_POP_BACK: begin
                    if (is_empty) begin
                        n_status = ST_EMPTY;
                    end else begin
                        n_popped   = r_back_word;
                        n_back_idx = back_prev;
                        n_count    = r_count - 1'b1;
                        if (r_count > CNT_W'(2)) begin
                            rd_en        = 1'b1;
                            rd_addr      = back_prev2;
                            n_pend_front = 1'b0;
                            n_state      = S_READ;
                            load_out     = 1'b0;
                        end else begin
                            n_back_word = r_front_word;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_front_idx <= '0;
            r_back_idx  <= '0;
            r_count     <= '0;
            o_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_front_idx <= n_front_idx;
            r_back_idx  <= n_back_idx;
            r_count     <= n_count;
            if (load_out) begin
                o_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                o_out_valid <= 1'b0;
            end
        end
        r_front_word  <= n_front_word;
        r_back_word   <= n_back_word;
        r_pend_front  <= n_pend_front;
        r_pend_popped <= n_popped;
        if (load_out) begin
            o_popped_value <= n_popped;
            o_status       <= n_status;
            o_count        <= n_count;
            o_front_value  <= (n_count == '0) ? '0 : n_front_word;
            o_back_value   <= (n_count == '0) ? '0 : n_back_word;
        end
    end

    dq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH),
        .AW    (IDX_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_value),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

endmodule

`default_nettype wire

// ----- tb/double_ended_queue_checker.sv -----
// Checker for the double-ended queue: predicts each result word and compares it.
`timescale 1ns / 1ps

module double_ended_queue_checker (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_in_valid,
    input  wire logic                                  i_in_stall,
    input  wire logic [dq_pkg::OP_W-1:0]               i_operation,
    input  wire logic [dq_pkg::DQ_DATA_WIDTH-1:0]      i_value,
    input  wire logic                                  i_out_valid,
    input  wire logic                                  i_out_stall,
    input  wire logic [dq_pkg::DQ_DATA_WIDTH-1:0]      i_popped_value,
    input  wire logic [dq_pkg::ST_W-1:0]               i_status,
    input  wire logic [$clog2(dq_pkg::DQ_DEPTH+1)-1:0] i_count,
    input  wire logic [dq_pkg::DQ_DATA_WIDTH-1:0]      i_front_value,
    input  wire logic [dq_pkg::DQ_DATA_WIDTH-1:0]      i_back_value,
    output int                                         o_fail_count,
    output int                                         o_pending,
    output int                                         o_checked,
    output int                                         o_full_seen,
    output int                                         o_empty_seen
);

    import dq_pkg::*;

    localparam int IDX_W = $clog2(DQ_DEPTH);
    localparam int CNT_W = $clog2(DQ_DEPTH + 1);

    typedef struct packed {
        logic [DQ_DATA_WIDTH-1:0] popped;
        logic [ST_W-1:0]          status;
        logic [CNT_W-1:0]         count;
        logic [DQ_DATA_WIDTH-1:0] front;
        logic [DQ_DATA_WIDTH-1:0] back;
    } t_dq_result;

    logic [DQ_DATA_WIDTH-1:0] ram [DQ_DEPTH];
    logic [IDX_W-1:0]         head;
    logic [IDX_W-1:0]         tail;
    int                       level;
    t_dq_result               result_q [$];

    function automatic logic [IDX_W-1:0] step_up(input logic [IDX_W-1:0] i);
        return (i == IDX_W'(DQ_DEPTH - 1)) ? '0 : i + 1'b1;
    endfunction

    function automatic logic [IDX_W-1:0] step_down(input logic [IDX_W-1:0] i);
        return (i == '0) ? IDX_W'(DQ_DEPTH - 1) : i - 1'b1;
    endfunction

    // tail points one past the back word
    task automatic apply_op(input logic [OP_W-1:0] op, input logic [DQ_DATA_WIDTH-1:0] word,
                            output t_dq_result r);
        r = '0;
        r.status = ST_OK;
        case (op) inside
            OP_PUSH_BACK, OP_PUSH_FRONT: begin
                if (level == DQ_DEPTH) begin
                    r.status = ST_FULL;
                end else if (op == OP_PUSH_BACK) begin
                    ram[tail] = word;
                    tail = step_up(tail);
                    level++;
                end else begin
                    head = step_down(head);
                    ram[head] = word;
                    level++;
                end
            end
            OP_POP_FRONT, OP_POP_BACK: begin
                if (level == 0) begin
                    r.status = ST_EMPTY;
                end else if (op == OP_POP_FRONT) begin
                    r.popped = ram[head];
                    head = step_up(head);
                    level--;
                end else begin
                    tail = step_down(tail);
                    r.popped = ram[tail];
                    level--;
                end
            end
            default: begin
            end
        endcase
        r.count = CNT_W'(level);
        if (level != 0) begin
            r.front = ram[head];
            r.back  = ram[step_down(tail)];
        end
    endtask

    task automatic check_field(input string name, input logic [DQ_DATA_WIDTH-1:0] want,
                               input logic [DQ_DATA_WIDTH-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_dq_result want;
        t_dq_result got;
        if (!i_rst_n) begin
            head = '0;
            tail = '0;
            level = 0;
            result_q.delete();
            o_fail_count = 0;
            o_checked = 0;
            o_full_seen = 0;
            o_empty_seen = 0;
        end else begin
            // results first: a word accepted now can't be the answer to one accepted now
            if (i_out_valid && !i_out_stall) begin
                got = '{i_popped_value, i_status, i_count, i_front_value, i_back_value};
                if (result_q.size() == 0) begin
                    $display("%0t: unexpected result word %p", $time, got);
                    o_fail_count++;
                end else begin
                    want = result_q.pop_front();
                    o_checked++;
                    check_field("popped_value", want.popped, got.popped);
                    check_field("status", DQ_DATA_WIDTH'(want.status), DQ_DATA_WIDTH'(got.status));
                    check_field("count", DQ_DATA_WIDTH'(want.count), DQ_DATA_WIDTH'(got.count));
                    check_field("front_value", want.front, got.front);
                    check_field("back_value", want.back, got.back);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                apply_op(i_operation, i_value, want);
                if (want.status == ST_FULL) o_full_seen++;
                if (want.status == ST_EMPTY) o_empty_seen++;
                result_q.push_back(want);
            end
        end
        o_pending = result_q.size();
    end

endmodule

// ----- tb/double_ended_queue_tb.sv -----
// Testbench top for the double-ended queue: stimulus, clock, reset and verdict.
`timescale 1ns / 1ps

module double_ended_queue_tb;

    import dq_pkg::*;

    localparam int CNT_W        = $clog2(DQ_DEPTH + 1);
    localparam int RANDOM_WORDS = 900;

    logic                     i_clk       = 1'b0;
    logic                     i_rst_n     = 1'b0;
    logic                     i_in_valid  = 1'b0;
    logic                     i_out_stall = 1'b0;
    logic [OP_W-1:0]          i_operation = OP_QUERY;
    logic [DQ_DATA_WIDTH-1:0] i_value     = '0;
    logic                     o_in_stall;
    logic                     o_out_valid;
    logic [DQ_DATA_WIDTH-1:0] o_popped_value;
    logic [ST_W-1:0]          o_status;
    logic [CNT_W-1:0]         o_count;
    logic [DQ_DATA_WIDTH-1:0] o_front_value;
    logic [DQ_DATA_WIDTH-1:0] o_back_value;

    int   fail_count;
    int   pending;
    int   checked;
    int   full_seen;
    int   empty_seen;
    int   sent   = 0;
    logic steady = 1'b0;

    double_ended_queue uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_operation    (i_operation),
        .i_value        (i_value),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_popped_value (o_popped_value),
        .o_status       (o_status),
        .o_count        (o_count),
        .o_front_value  (o_front_value),
        .o_back_value   (o_back_value)
    );

    double_ended_queue_checker checker_i (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_operation    (i_operation),
        .i_value        (i_value),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_popped_value (o_popped_value),
        .i_status       (o_status),
        .i_count        (o_count),
        .i_front_value  (o_front_value),
        .i_back_value   (o_back_value),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_checked      (checked),
        .o_full_seen    (full_seen),
        .o_empty_seen   (empty_seen)
    );

    always #1 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        if (steady) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < 38);
        end
    end

    // called at a falling edge; returns at the falling edge after the word is taken
    task automatic send_word(input logic [OP_W-1:0] op, input logic [DQ_DATA_WIDTH-1:0] val);
        while (!steady && $urandom_range(0, 99) < 38) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_operation <= op;
        i_value     <= val;
        do @(posedge i_clk); while (!(i_in_valid && !o_in_stall));
        @(negedge i_clk);
        sent++;
    endtask

    initial begin
        int                       rnd;
        int                       span;
        int                       j;
        int                       pick;
        int                       push_bar;
        int                       pop_bar;
        logic [OP_W-1:0]          op;
        logic [DQ_DATA_WIDTH-1:0] val;

        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // empty queue, both end values, unused codes, drain back to empty
        send_word(OP_QUERY, $urandom);
        send_word(OP_POP_FRONT, $urandom);
        send_word(OP_POP_BACK, $urandom);
        send_word(OP_PUSH_BACK, '0);
        send_word(OP_PUSH_FRONT, '1);
        send_word(OP_QUERY, '0);
        send_word(OP_POP_BACK + 3'd1, $urandom);
        send_word(OP_POP_BACK + 3'd2, $urandom);
        send_word(OP_POP_BACK + 3'd3, $urandom);
        send_word(OP_PUSH_BACK, 32'hA5A5_A5A5);
        send_word(OP_PUSH_FRONT, 32'h5A5A_5A5A);
        send_word(OP_POP_BACK, '1);
        send_word(OP_POP_FRONT, '1);
        send_word(OP_POP_FRONT, '0);
        send_word(OP_POP_BACK, '0);
        send_word(OP_POP_FRONT, '0);
        send_word(OP_PUSH_FRONT, 32'h0000_0001);
        send_word(OP_POP_BACK, '0);

        // phases lean toward filling, draining or mixing so both full and empty get hit
        rnd = 0;
        while (rnd < RANDOM_WORDS) begin
            case ($urandom_range(0, 2))
                0:       begin push_bar = 72; pop_bar = 88; end
                1:       begin push_bar = 16; pop_bar = 88; end
                default: begin push_bar = 42; pop_bar = 84; end
            endcase
            span = $urandom_range(60, 160);
            for (j = 0; j < span && rnd < RANDOM_WORDS; j++) begin
                steady <= (rnd >= 350 && rnd < 550);
                pick = $urandom_range(0, 99);
                if (pick < push_bar) begin
                    op = $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
                end else if (pick < pop_bar) begin
                    op = $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
                end else if (pick < 96) begin
                    op = OP_QUERY;
                end else begin
                    op = OP_POP_BACK + OP_W'($urandom_range(1, 3));
                end
                case ($urandom_range(0, 9))
                    0:       val = '0;
                    1:       val = '1;
                    default: val = $urandom;
                endcase
                send_word(op, val);
                rnd++;
            end
        end
        steady     <= 1'b0;
        i_in_valid <= 1'b0;

        wait (pending == 0);
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);

        $display("Sent %0d operations (%0d random), checked %0d result words.", sent, rnd, checked);
        $display("Pushes refused as full: %0d, pops refused as empty: %0d.", full_seen,
                 empty_seen);
        if (fail_count == 0) begin
            $display("** double_ended_queue: PASSED **");
        end else begin
            $display("** double_ended_queue: FAILED **");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("** double_ended_queue: FAILED **");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/dq_pkg.sv
rtl/dq_ram.sv
rtl/double_ended_queue.sv
tb/double_ended_queue_checker.sv
tb/double_ended_queue_tb.sv
